### rtl/core/plt_pkg.sv
// Package for the pure-literal tracker: store sizes, derived widths and opcodes.
// No dependencies; imported by pure_literal_tracker_top and plt_checker.
package plt_pkg;

    localparam int STORE_DEPTH  = 64;
    localparam int LITERAL_BITS = 16;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int FILL_W  = $clog2(STORE_DEPTH + 1);
    localparam int COUNT_W = 7;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [LITERAL_BITS-1:0] lit_t;
    typedef logic [FILL_W-1:0]       fill_t;
    typedef logic [ADDR_W-1:0]       addr_t;

endpackage

### rtl/core/pure_literal_tracker_top.sv
// Pure-literal candidate tracker, top level: sequencer, candidate and closed memories,
// output register. Depends on plt_pkg.
//
// Each transfer in gives exactly one result. An add walks the closed store one entry a
// cycle, then the candidate store one entry a cycle, and on a removal compacts the tail of
// the candidate store past the match one entry a cycle through the single-port read path
// of that memory; a final read fetches the newest candidate. Either scan stops early on a
// match; the stores hold 64 entries each. A result waiting in the output register delays
// the next one. One item is in work at a time; the next input transfer is taken while the
// previous result still waits in the output register.
module pure_literal_tracker_top
    import plt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic signed [LITERAL_BITS-1:0] literal,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [LITERAL_BITS-1:0] pure_candidate,
    output logic [COUNT_W-1:0]             candidate_count,
    output logic [COUNT_W-1:0]             closed_count,
    output logic                           overflow
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CSCAN = 3'd1;
    localparam logic [2:0] ST_KSCAN = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_TOP   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    fill_t      idx_reg, idx_next;
    addr_t      rd_idx_reg, rd_idx_next;
    logic       rd_vld_reg, rd_vld_next;
    lit_t       lit_reg, lit_next;
    lit_t       opp_reg, opp_next;
    fill_t      cand_fill_reg, cand_fill_next;
    fill_t      clos_fill_reg, clos_fill_next;
    logic       ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    lit_t               out_cand_reg, out_cand_next;
    logic [COUNT_W-1:0] out_ccnt_reg, out_ccnt_next;
    logic [COUNT_W-1:0] out_xcnt_reg, out_xcnt_next;
    logic               out_ovf_reg, out_ovf_next;

    lit_t cand_mem [STORE_DEPTH];
    lit_t clos_mem [STORE_DEPTH];
    lit_t cand_rdata_reg;
    lit_t clos_rdata_reg;

    logic  cand_we, cand_re, clos_we, clos_re;
    addr_t cand_waddr, cand_raddr, clos_raddr, clos_waddr;
    lit_t  cand_wdata;
    fill_t top_idx;
    logic  c_hit, k_opp, k_lit;

    assign top_idx = cand_fill_reg - fill_t'(1);
    assign c_hit   = rd_vld_reg && (clos_rdata_reg == lit_reg || clos_rdata_reg == opp_reg);
    assign k_opp   = rd_vld_reg && (cand_rdata_reg == opp_reg);
    assign k_lit   = rd_vld_reg && (cand_rdata_reg == lit_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = rd_vld_reg;
        lit_next       = lit_reg;
        opp_next       = opp_reg;
        cand_fill_next = cand_fill_reg;
        clos_fill_next = clos_fill_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_cand_next  = out_cand_reg;
        out_ccnt_next  = out_ccnt_reg;
        out_xcnt_next  = out_xcnt_reg;
        out_ovf_next   = out_ovf_reg;
        cand_we        = 1'b0;
        cand_re        = 1'b0;
        cand_waddr     = cand_fill_reg[ADDR_W-1:0];
        cand_raddr     = idx_reg[ADDR_W-1:0];
        cand_wdata     = lit_reg;
        clos_we        = 1'b0;
        clos_re        = 1'b0;
        clos_waddr     = clos_fill_reg[ADDR_W-1:0];
        clos_raddr     = idx_reg[ADDR_W-1:0];
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lit_next    = lit_t'(literal);
                    opp_next    = ~lit_t'(literal) + lit_t'(1);
                    ovf_next    = 1'b0;
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    if (opcode == OP_CLEAR)
                    begin
                        cand_fill_next = '0;
                        clos_fill_next = '0;
                        state_next     = ST_TOP;
                    end
                    else
                    begin
                        state_next = ST_CSCAN;
                    end
                end
            end
            ST_CSCAN:
            begin
                if (c_hit)
                begin
                    state_next = ST_TOP;
                end
                else if (idx_reg < clos_fill_reg)
                begin
                    clos_re     = 1'b1;
                    rd_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next    = idx_reg + fill_t'(1);
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                    state_next  = ST_KSCAN;
                end
            end
            ST_KSCAN:
            begin
                if (k_opp)
                begin
                    idx_next    = fill_t'(rd_idx_reg) + fill_t'(1);
                    rd_vld_next = 1'b0;
                    state_next  = ST_SHIFT;
                end
                else if (k_lit)
                begin
                    state_next = ST_TOP;
                end
                else if (idx_reg < cand_fill_reg)
                begin
                    cand_re     = 1'b1;
                    rd_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next    = idx_reg + fill_t'(1);
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    // not listed in either polarity: append
                    if (cand_fill_reg < fill_t'(STORE_DEPTH))
                    begin
                        cand_we        = 1'b1;
                        cand_fill_next = cand_fill_reg + fill_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_TOP;
                end
            end
            ST_SHIFT:
            begin
                if (rd_vld_reg)
                begin
                    cand_we    = 1'b1;
                    cand_waddr = rd_idx_reg - addr_t'(1);
                    cand_wdata = cand_rdata_reg;
                end
                if (idx_reg < cand_fill_reg)
                begin
                    cand_re     = 1'b1;
                    rd_idx_next = idx_reg[ADDR_W-1:0];
                    idx_next    = idx_reg + fill_t'(1);
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    rd_vld_next    = 1'b0;
                    cand_fill_next = cand_fill_reg - fill_t'(1);
                    if (clos_fill_reg < fill_t'(STORE_DEPTH))
                    begin
                        clos_we        = 1'b1;
                        clos_fill_next = clos_fill_reg + fill_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                cand_raddr = top_idx[ADDR_W-1:0];
                cand_re    = (cand_fill_reg != '0);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_cand_next  = (cand_fill_reg == '0) ? lit_t'(0) : cand_rdata_reg;
                    out_ccnt_next  = COUNT_W'(cand_fill_reg);
                    out_xcnt_next  = COUNT_W'(clos_fill_reg);
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            cand_fill_reg <= '0;
            clos_fill_reg <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            cand_fill_reg <= cand_fill_next;
            clos_fill_reg <= clos_fill_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        lit_reg      <= lit_next;
        opp_reg      <= opp_next;
        out_cand_reg <= out_cand_next;
        out_ccnt_reg <= out_ccnt_next;
        out_xcnt_reg <= out_xcnt_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // candidate store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cand_we)
        begin
            cand_mem[cand_waddr] <= cand_wdata;
        end
        if (cand_re)
        begin
            cand_rdata_reg <= cand_mem[cand_raddr];
        end
    end

    // closed store
    always_ff @(posedge clk)
    begin
        if (clos_we)
        begin
            clos_mem[clos_waddr] <= lit_reg;
        end
        if (clos_re)
        begin
            clos_rdata_reg <= clos_mem[clos_raddr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign pure_candidate  = out_cand_reg;
    assign candidate_count = out_ccnt_reg;
    assign closed_count    = out_xcnt_reg;
    assign overflow        = out_ovf_reg;

endmodule

### rtl/core/plt_checker.sv
// Port-level checker for the pure-literal tracker, bound to the top level.
// Depends on plt_pkg and pure_literal_tracker_top.
module plt_checker
    import plt_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [LITERAL_BITS-1:0] pure_candidate,
    input logic [COUNT_W-1:0]             candidate_count,
    input logic [COUNT_W-1:0]             closed_count,
    input logic                           overflow
);

    // one item at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pure_candidate)
            && $stable(candidate_count) && $stable(closed_count) && $stable(overflow))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && candidate_count == '0 |-> pure_candidate == '0)
        else $error("empty list with nonzero candidate");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            candidate_count == COUNT_W'(STORE_DEPTH) || closed_count == COUNT_W'(STORE_DEPTH))
        else $error("overflow with no full store");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> candidate_count <= COUNT_W'(STORE_DEPTH)
            && closed_count <= COUNT_W'(STORE_DEPTH))
        else $error("count beyond store depth");

endmodule

bind pure_literal_tracker_top plt_checker u_plt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pure_candidate  (pure_candidate),
    .candidate_count (candidate_count),
    .closed_count    (closed_count),
    .overflow        (overflow)
);
